>>> design/assert_macros.svh
// Assertion macros used by the checker file.
// Include this header by bare name; it has no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define SWMM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion, checked during reset as well.
`define SWMM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/swmm_pkg.sv
// Shared constants for the sliding window min/max/sum block.
// No dependencies; every file but assert_macros.svh refers to it by scoped names.
package swmm_pkg;

  localparam int WINDOW_MAX_DEF   = 16;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int SUM_W            = 48;
  localparam int WSIZE_W          = 5;
  localparam int PADDR_W          = 3;
  localparam int PDATA_W          = 32;

  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 5'd4;

  // Register select: word index bit of paddr.
  localparam logic REG_WINDOW_SIZE = 1'b0;

endpackage

>>> design/swmm_in_if.sv
// Input channel: one signed sample and an end-of-stream flag per transaction.
// Depends on swmm_pkg.
interface swmm_in_if #(
  parameter int SAMPLE_WIDTH = swmm_pkg::SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           last;

  modport source (output valid, sample, last, input ready);
  modport sink   (input valid, sample, last, output ready);
endinterface

>>> design/swmm_out_if.sv
// Result channel: window max/min, full flag, running sum, end-of-stream flag.
// Depends on swmm_pkg.
interface swmm_out_if #(
  parameter int SAMPLE_WIDTH = swmm_pkg::SAMPLE_WIDTH_DEF
) ();
  logic                             valid;
  logic                             ready;
  logic signed [SAMPLE_WIDTH-1:0]   window_max;
  logic signed [SAMPLE_WIDTH-1:0]   window_min;
  logic                             window_full;
  logic signed [swmm_pkg::SUM_W-1:0] min_max_sum;
  logic                             end_of_stream;

  modport source (output valid, window_max, window_min, window_full, min_max_sum,
                  end_of_stream, input ready);
  modport sink   (input valid, window_max, window_min, window_full, min_max_sum,
                  end_of_stream, output ready);
endinterface

>>> design/swmm_cell.sv
// One cell of the suffix max/min chain: holds max and min over its age range.
// Depends on swmm_pkg; instantiated by the top level.
module swmm_cell #(
  parameter int SAMPLE_WIDTH = swmm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [SAMPLE_WIDTH-1:0] new_sample,
  input  logic signed [SAMPLE_WIDTH-1:0] prev_max,
  input  logic signed [SAMPLE_WIDTH-1:0] prev_min,
  output logic signed [SAMPLE_WIDTH-1:0] max_q,
  output logic signed [SAMPLE_WIDTH-1:0] min_q
);

  always_ff @(posedge clk) begin
    if (en) begin
      max_q <= (prev_max > new_sample) ? prev_max : new_sample;
      min_q <= (prev_min < new_sample) ? prev_min : new_sample;
    end
  end

endmodule

>>> design/swmm_apb_regs.sv
// APB register file: holds window_size.
// Depends on swmm_pkg.
module swmm_apb_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [swmm_pkg::PADDR_W-1:0]       paddr,
  input  logic [swmm_pkg::PDATA_W-1:0]       pwdata,
  output logic [swmm_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready,
  output logic [swmm_pkg::WSIZE_W-1:0]       window_size
);

  logic reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[swmm_pkg::PADDR_W-1] == swmm_pkg::REG_WINDOW_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= swmm_pkg::WSIZE_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      window_size <= pwdata[swmm_pkg::WSIZE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = {{(swmm_pkg::PDATA_W-swmm_pkg::WSIZE_W){1'b0}}, window_size};
    end
  end

endmodule

>>> design/sliding_window_min_max_sum.sv
// Sliding window min/max/sum, top level.
// Depends on swmm_pkg, swmm_in_if, swmm_out_if, swmm_cell, swmm_apb_regs.
//
// Usage:
//   in_ch carries one signed sample and a last flag per transaction; out_ch
//   returns one result per sample: max and min of the live window, a full
//   flag, the 48-bit wrapping sum of max+min over full windows, and a copy
//   of last. The APB port sets window_size (byte address 0, reset value 4).
//   An accepted sample is registered in the cell chain and middle stage,
//   then its result in the result register, which drives out_ch.
//   Throughput: one sample per cycle while out_ch does not stall. Each cell
//   but the head compares its neighbor's value with the new sample. After a
//   last sample the stream state clears; window_size stays.
//   Reset clears the stream state and both pipeline stages and restores
//   window_size to 4. When out_ch stalls, the result register holds and one
//   more sample is taken into the middle stage; then in_ch.ready drops until
//   the result is taken. Write window_size only while no result is pending.
//   Shrinking the window drops samples that are too old at once.
module sliding_window_min_max_sum #(
  parameter int WINDOW_MAX   = swmm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = swmm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  swmm_in_if.sink                      in_ch,
  swmm_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [swmm_pkg::PADDR_W-1:0] paddr,
  input  logic [swmm_pkg::PDATA_W-1:0] pwdata,
  output logic [swmm_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SUM_W = swmm_pkg::SUM_W;

  logic [swmm_pkg::WSIZE_W-1:0] window_size;
  logic [CNT_W-1:0]             win_eff;

  logic signed [SAMPLE_WIDTH-1:0] cell_max [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] cell_min [WINDOW_MAX];

  logic             accept_in;
  logic             load_out;
  logic [CNT_W-1:0] live_cnt, live_cnt_next;
  logic [CNT_W-1:0] seen, seen_next;
  logic             mid_valid;
  logic             mid_full;
  logic             mid_last;
  logic [IDX_W-1:0] mid_idx;

  logic signed [SAMPLE_WIDTH-1:0] sel_max, sel_min;
  logic signed [SUM_W-1:0]        running_sum;
  logic signed [SUM_W-1:0]        sum_add, sum_next;

  logic                           out_valid;
  logic signed [SAMPLE_WIDTH-1:0] out_max, out_min;
  logic                           out_full, out_eos;
  logic signed [SUM_W-1:0]        out_sum;

  swmm_apb_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .window_size (window_size)
  );

  always_comb begin
    if (window_size == '0) begin
      win_eff = CNT_W'(1);
    end else if (32'(window_size) > 32'(WINDOW_MAX)) begin
      win_eff = CNT_W'(WINDOW_MAX);
    end else begin
      win_eff = CNT_W'(window_size);
    end
  end

  assign load_out    = mid_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !mid_valid || load_out;
  assign accept_in   = in_ch.valid && in_ch.ready;

  // Cell chain: cell i holds max/min over the samples of age 0..i.
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    if (i == 0) begin : g_head
      swmm_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cell (
        .clk        (clk),
        .en         (accept_in),
        .new_sample (in_ch.sample),
        .prev_max   (in_ch.sample),
        .prev_min   (in_ch.sample),
        .max_q      (cell_max[i]),
        .min_q      (cell_min[i])
      );
    end else begin : g_body
      swmm_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cell (
        .clk        (clk),
        .en         (accept_in),
        .new_sample (in_ch.sample),
        .prev_max   (cell_max[i-1]),
        .prev_min   (cell_min[i-1]),
        .max_q      (cell_max[i]),
        .min_q      (cell_min[i])
      );
    end
  end

  always_comb begin
    live_cnt_next = (live_cnt >= win_eff) ? win_eff : live_cnt + CNT_W'(1);
    seen_next     = (seen < CNT_W'(WINDOW_MAX)) ? seen + CNT_W'(1) : seen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_cnt  <= '0;
      seen      <= '0;
      mid_valid <= 1'b0;
    end else begin
      if (accept_in) begin
        mid_valid <= 1'b1;
        if (in_ch.last) begin
          live_cnt <= '0;
          seen     <= '0;
        end else begin
          live_cnt <= live_cnt_next;
          seen     <= seen_next;
        end
      end else if (load_out) begin
        mid_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      mid_full <= (seen_next >= win_eff);
      mid_last <= in_ch.last;
      mid_idx  <= IDX_W'(live_cnt_next - CNT_W'(1));
    end
  end

  always_comb begin
    sel_max  = cell_max[mid_idx];
    sel_min  = cell_min[mid_idx];
    sum_add  = running_sum
             + {{(SUM_W-SAMPLE_WIDTH){sel_max[SAMPLE_WIDTH-1]}}, sel_max}
             + {{(SUM_W-SAMPLE_WIDTH){sel_min[SAMPLE_WIDTH-1]}}, sel_min};
    sum_next = mid_full ? sum_add : running_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid   <= 1'b1;
        running_sum <= mid_last ? '0 : sum_next;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_max  <= sel_max;
      out_min  <= sel_min;
      out_full <= mid_full;
      out_sum  <= sum_next;
      out_eos  <= mid_last;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.window_max    = out_max;
  assign out_ch.window_min    = out_min;
  assign out_ch.window_full   = out_full;
  assign out_ch.min_max_sum   = out_sum;
  assign out_ch.end_of_stream = out_eos;

endmodule

>>> design/swmm_checker.sv
// Port-level checker for the sliding window block, bound to the top level.
// Depends on swmm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module swmm_checker #(
  parameter int SAMPLE_WIDTH = swmm_pkg::SAMPLE_WIDTH_DEF
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [SAMPLE_WIDTH-1:0]    window_max,
  input logic signed [SAMPLE_WIDTH-1:0]    window_min,
  input logic                              window_full,
  input logic signed [swmm_pkg::SUM_W-1:0] min_max_sum,
  input logic                              end_of_stream
);

  `SWMM_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !out_valid, "result valid after reset")

  `SWMM_ASSERT(a_stall_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(window_max) && $stable(window_min) && $stable(window_full) && $stable(min_max_sum) && $stable(end_of_stream), "stalled result changed")

  `SWMM_ASSERT(a_min_le_max, clk, rst, out_valid |-> window_min <= window_max, "window min above max")

  `SWMM_ASSERT(a_backpressure, clk, rst, !in_ready |-> out_valid && !out_ready, "input stalled without output stall")

endmodule

bind sliding_window_min_max_sum swmm_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_swmm_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .window_max    (out_ch.window_max),
  .window_min    (out_ch.window_min),
  .window_full   (out_ch.window_full),
  .min_max_sum   (out_ch.min_max_sum),
  .end_of_stream (out_ch.end_of_stream)
);
